// ===== sv/bpa_pkg.sv =====
// shared constants, types and codes for the bitmap page allocator
package bpa_pkg;

	localparam int NUM_PAGES   = 4096;
	localparam int PAGE_SHIFT  = 12;
	localparam int WORD_W      = 64;
	localparam int NUM_WORDS   = NUM_PAGES / WORD_W;
	localparam int PAGE_W      = $clog2(NUM_PAGES);
	localparam int WORD_IDX_W  = $clog2(NUM_WORDS);
	localparam int BIT_IDX_W   = $clog2(WORD_W);
	localparam int CHUNK_W     = 8;
	localparam int CHUNK_IDX_W = $clog2(WORD_W / CHUNK_W);
	localparam int POP_W       = $clog2(WORD_W) + 1;

	localparam int ACTION_W    = 2;
	localparam int ADDR_W      = 24;
	localparam int COUNT_W     = 13;
	localparam int STATUS_W    = 2;

	localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_FREE    = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_RESERVE = 2'd2;

	localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STS_NOMEM = 2'd1;
	localparam logic [STATUS_W-1:0] STS_RANGE = 2'd2;
	localparam logic [STATUS_W-1:0] STS_ZERO  = 2'd3;

	typedef logic [WORD_W-1:0]     word_t;
	typedef logic [WORD_IDX_W-1:0] word_idx_t;
	typedef logic [PAGE_W-1:0]     page_t;

	typedef struct packed {
		logic      rd_en;
		logic      wr_en;
		word_idx_t addr;
		word_t     wdata;
	} bpa_mem_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRD,
		ST_SCAN,
		ST_MRD,
		ST_MOD,
		ST_CNT,
		ST_FIN
	} bpa_state_t;

endpackage

// ===== sv/bpa_in_if.sv =====
// request channel: action, base address and page count
interface bpa_in_if;
	import bpa_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [ADDR_W-1:0]   base_address;
	logic [COUNT_W-1:0]  page_count;

	modport source (output valid, action, base_address, page_count, input ready);
	modport sink (input valid, action, base_address, page_count, output ready);

endinterface

// ===== sv/bpa_out_if.sv =====
// response channel: status, run address and page counts
interface bpa_out_if;
	import bpa_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ADDR_W-1:0]   run_address;
	logic [COUNT_W-1:0]  used_pages;
	logic [COUNT_W-1:0]  free_pages;

	modport source (output valid, status, run_address, used_pages, free_pages, input ready);
	modport sink (input valid, status, run_address, used_pages, free_pages, output ready);

endinterface

// ===== sv/bpa_bitmap.sv =====
// used-bit bitmap memory, one word per row, unwritten rows read as all used
module bpa_bitmap
	import bpa_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  bpa_mem_req_t req,
	output word_t        rd_word
);

	word_t                mem_q [NUM_WORDS];
	logic [NUM_WORDS-1:0] row_valid_q;
	word_t                rd_data_q;
	logic                 rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (req.wr_en) begin
				row_valid_q[req.addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= row_valid_q[req.addr];
			end
		end
	end

	assign rd_word = rd_valid_q ? rd_data_q : '1;

endmodule

// ===== sv/bitmap_page_allocator_core.sv =====
// first-fit bitmap page allocator: sequencer, scan and run marking
//
//  channel | dir | handshake     | word
//  req     | in  | valid / ready | action, base_address, page_count
//  rsp     | out | valid / ready | status, run_address, used_pages, free_pages
//
// allocate scans one 64-bit bitmap word per cycle when the word is all used or
// all free, else one byte per cycle, then marks the run
// free and reserve mark the run word by word (write in ST_MOD, count in ST_CNT), through one memory port
// zero counts, range errors, oversize allocations and the ignored action go from idle straight to ST_FIN
// reset leaves every page used with no clearing pass; req is ready only when idle
// a waiting response does not block the next request, only its completion
module bitmap_page_allocator_core
	import bpa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	bpa_in_if.sink    req,
	bpa_out_if.source rsp
);

	bpa_state_t   state_q, state_d;
	bpa_mem_req_t mem_req;
	word_t        rd_word;

	logic [STATUS_W-1:0]    status_q;
	logic [COUNT_W-1:0]     cnt_q;
	logic [COUNT_W-1:0]     used_q;
	logic [COUNT_W-1:0]     run_q;
	page_t                  start_q;
	page_t                  first_q;
	page_t                  last_q;
	page_t                  res_page_q;
	word_idx_t              w_q;
	logic [CHUNK_IDX_W-1:0] b_q;
	logic                   mark_q;
	word_t                  chg_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [ADDR_W-1:0]   out_addr_q;
	logic [COUNT_W-1:0]  out_used_q;

	bpa_bitmap u_bitmap (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_word (rd_word)
	);

	// request decode
	logic                 in_fire;
	page_t                in_page;
	logic [COUNT_W:0]     in_end;
	logic                 cnt_zero;
	logic                 too_big;
	logic                 range_bad;
	logic                 act_known;

	assign in_fire   = req.valid && req.ready;
	assign in_page   = req.base_address[PAGE_SHIFT +: PAGE_W];
	assign in_end    = (COUNT_W+1)'(in_page) + (COUNT_W+1)'(req.page_count);
	assign cnt_zero  = (req.page_count == '0);
	assign too_big   = (req.page_count > COUNT_W'(NUM_PAGES));
	assign range_bad = (in_end > (COUNT_W+1)'(NUM_PAGES));
	assign act_known = (req.action == ACT_ALLOC) || (req.action == ACT_FREE)
		|| (req.action == ACT_RESERVE);

	// scan step
	logic             last_word;
	logic             word_done;
	logic             scan_found;
	logic [COUNT_W-1:0] run_v;
	page_t            start_v;
	logic [COUNT_W:0] run_ext;

	assign last_word = (w_q == WORD_IDX_W'(NUM_WORDS - 1));
	assign run_ext   = (COUNT_W+1)'(run_q) + (COUNT_W+1)'(WORD_W);

	always_comb begin
		logic fnd;
		logic used_bit;
		run_v     = run_q;
		start_v   = start_q;
		fnd       = 1'b0;
		used_bit  = 1'b0;
		word_done = (b_q == '1);
		if (b_q == '0 && rd_word == '1) begin
			run_v     = '0;
			word_done = 1'b1;
		end else if (b_q == '0 && rd_word == '0) begin
			word_done = 1'b1;
			if (run_q == '0) begin
				start_v = {w_q, BIT_IDX_W'(0)};
			end
			if (run_ext >= (COUNT_W+1)'(cnt_q)) begin
				fnd = 1'b1;
			end else begin
				run_v = run_ext[COUNT_W-1:0];
			end
		end else begin
			for (int i = 0; i < CHUNK_W; i++) begin
				used_bit = rd_word[{b_q, (BIT_IDX_W-CHUNK_IDX_W)'(i)}];
				if (!fnd) begin
					if (used_bit) begin
						run_v = '0;
					end else begin
						if (run_v == '0) begin
							start_v = {w_q, b_q, (BIT_IDX_W-CHUNK_IDX_W)'(i)};
						end
						run_v = run_v + 1'b1;
						if (run_v == cnt_q) begin
							fnd = 1'b1;
						end
					end
				end
			end
		end
		scan_found = fnd;
	end

	// run marking
	logic [BIT_IDX_W-1:0] lo_bit;
	logic [BIT_IDX_W-1:0] hi_bit;
	word_t                mark_mask;
	word_t                new_word;
	logic                 mark_last;

	assign lo_bit    = (w_q == first_q[PAGE_W-1 -: WORD_IDX_W]) ? first_q[BIT_IDX_W-1:0] : '0;
	assign hi_bit    = (w_q == last_q[PAGE_W-1 -: WORD_IDX_W]) ? last_q[BIT_IDX_W-1:0] : '1;
	assign mark_mask = ({WORD_W{1'b1}} << lo_bit) & ({WORD_W{1'b1}} >> (~hi_bit));
	assign new_word  = mark_q ? (rd_word | mark_mask) : (rd_word & ~mark_mask);
	assign mark_last = (w_q == last_q[PAGE_W-1 -: WORD_IDX_W]);

	function automatic logic [POP_W-1:0] popcnt(input word_t v);
		logic [CHUNK_IDX_W+1:0] bc [WORD_W/CHUNK_W];
		logic [POP_W-1:0]       s;
		s = '0;
		for (int j = 0; j < WORD_W / CHUNK_W; j++) begin
			bc[j] = '0;
			for (int k = 0; k < CHUNK_W; k++) begin
				bc[j] = bc[j] + (CHUNK_IDX_W+2)'(v[j*CHUNK_W + k]);
			end
		end
		for (int j = 0; j < WORD_W / CHUNK_W; j++) begin
			s = s + POP_W'(bc[j]);
		end
		return s;
	endfunction

	logic out_load;
	assign out_load = !out_valid_q || rsp.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (cnt_zero) begin
						state_d = ST_FIN;
					end else begin
						case (req.action)
							ACT_ALLOC:   state_d = too_big ? ST_FIN : ST_SRD;
							ACT_FREE,
							ACT_RESERVE: state_d = range_bad ? ST_FIN : ST_MRD;
							default:     state_d = ST_FIN;
						endcase
					end
				end
			end
			ST_SRD: state_d = ST_SCAN;
			ST_SCAN: begin
				if (scan_found) begin
					state_d = ST_MRD;
				end else if (word_done && last_word) begin
					state_d = ST_FIN;
				end
			end
			ST_MRD: state_d = ST_MOD;
			ST_MOD: state_d = ST_CNT;
			ST_CNT: state_d = mark_last ? ST_FIN : ST_MOD;
			ST_FIN: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		mem_req       = '0;
		mem_req.addr  = w_q;
		mem_req.wdata = new_word;
		req.ready     = 1'b0;
		case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_SRD,
			ST_MRD: mem_req.rd_en = 1'b1;
			ST_SCAN: begin
				mem_req.rd_en = word_done && !scan_found && !last_word;
				mem_req.addr  = w_q + 1'b1;
			end
			ST_MOD: mem_req.wr_en = 1'b1;
			ST_CNT: begin
				mem_req.rd_en = !mark_last;
				mem_req.addr  = w_q + 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			status_q     <= STS_OK;
			cnt_q        <= '0;
			used_q       <= COUNT_W'(NUM_PAGES);
			run_q        <= '0;
			start_q      <= '0;
			first_q      <= '0;
			last_q       <= '0;
			res_page_q   <= '0;
			w_q          <= '0;
			b_q          <= '0;
			mark_q       <= 1'b0;
			chg_q        <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= STS_OK;
			out_addr_q   <= '0;
			out_used_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FIN && out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						cnt_q      <= req.page_count;
						run_q      <= '0;
						start_q    <= '0;
						b_q        <= '0;
						res_page_q <= '0;
						first_q    <= in_page;
						last_q     <= PAGE_W'(in_end - 1'b1);
						mark_q     <= (req.action != ACT_FREE);
						w_q        <= (req.action == ACT_ALLOC) ? '0
							: in_page[PAGE_W-1 -: WORD_IDX_W];
						if (cnt_zero && act_known) begin
							status_q <= STS_ZERO;
						end else if (req.action == ACT_ALLOC && too_big) begin
							status_q <= STS_NOMEM;
						end else if ((req.action == ACT_FREE || req.action == ACT_RESERVE)
							&& range_bad) begin
							status_q <= STS_RANGE;
						end else begin
							status_q <= STS_OK;
						end
					end
				end
				ST_SCAN: begin
					run_q   <= run_v;
					start_q <= start_v;
					if (scan_found) begin
						first_q    <= start_v;
						last_q     <= PAGE_W'(start_v + cnt_q - 1'b1);
						w_q        <= start_v[PAGE_W-1 -: WORD_IDX_W];
						res_page_q <= start_v;
					end else if (word_done) begin
						b_q <= '0;
						if (last_word) begin
							status_q <= STS_NOMEM;
						end else begin
							w_q <= w_q + 1'b1;
						end
					end else begin
						b_q <= b_q + 1'b1;
					end
				end
				ST_MOD: chg_q <= rd_word ^ new_word;
				ST_CNT: begin
					if (mark_q) begin
						used_q <= used_q + COUNT_W'(popcnt(chg_q));
					end else begin
						used_q <= used_q - COUNT_W'(popcnt(chg_q));
					end
					if (!mark_last) begin
						w_q <= w_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						out_status_q <= status_q;
						out_addr_q   <= ADDR_W'({res_page_q, PAGE_SHIFT'(0)});
						out_used_q   <= used_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.run_address = out_addr_q;
	assign rsp.used_pages  = out_used_q;
	assign rsp.free_pages  = COUNT_W'(NUM_PAGES) - out_used_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= COUNT_W'(NUM_PAGES))
		else $error("used count above page total");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != STS_OK |-> rsp.run_address == '0)
		else $error("run address set on error");

	assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |-> state_q == ST_MOD)
		else $error("bitmap write outside marking");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN && scan_found |=> state_q == ST_MRD && res_page_q == first_q)
		else $error("found run not handed to marking");

endmodule

// ===== test/tb_bitmap_page_allocator_core.sv =====
// self-checking testbench for the first-fit bitmap page allocator core
module tb_bitmap_page_allocator_core
	import bpa_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam int RAND_PER_PHASE = 360;
	localparam int HOLD_CYCLES    = 400;
	localparam int TAIL_CYCLES    = 800;
	localparam int CYCLE_LIMIT    = 6000000;
	localparam int MAX_PRINTS     = 40;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   run_address;
		logic [COUNT_W-1:0]  used_pages;
		logic [COUNT_W-1:0]  free_pages;
	} alloc_reply_t;

	typedef struct {
		int unsigned first;
		int unsigned len;
	} page_run_t;

	class alloc_scoreboard;
		bit [NUM_PAGES-1:0] page_used;
		int unsigned        used_total;
		alloc_reply_t       expected_replies[$];
		page_run_t          live_runs[$];
		int                 errors;

		function new();
			page_used  = '1;
			used_total = NUM_PAGES;
			errors     = 0;
		endfunction

		function void mark_run(int unsigned first, int unsigned len, bit used);
			for (int unsigned p = first; p < first + len && p < NUM_PAGES; p++) begin
				if (page_used[p] != used) begin
					page_used[p] = used;
					if (used)
						used_total++;
					else
						used_total--;
				end
			end
		endfunction

		function bit find_free_run(int unsigned len, output int unsigned first);
			int unsigned run;
			run   = 0;
			first = 0;
			if (len > NUM_PAGES)
				return 1'b0;
			for (int unsigned p = 0; p < NUM_PAGES; p++) begin
				if (page_used[p]) begin
					run = 0;
				end else begin
					if (run == 0)
						first = p;
					run++;
					if (run == len)
						return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		// predict the reply for one accepted request word and update the bitmap
		function void apply_request(logic [ACTION_W-1:0] act, logic [ADDR_W-1:0] addr,
				logic [COUNT_W-1:0] cnt);
			alloc_reply_t r;
			int unsigned  base_pg;
			int unsigned  first;
			page_run_t    pr;
			r       = '0;
			base_pg = addr >> PAGE_SHIFT;
			if (act == ACT_ALLOC || act == ACT_FREE || act == ACT_RESERVE) begin
				if (cnt == 0) begin
					r.status = STS_ZERO;
				end else if (act == ACT_ALLOC) begin
					if (find_free_run(cnt, first)) begin
						mark_run(first, cnt, 1'b1);
						r.run_address = ADDR_W'(first << PAGE_SHIFT);
						pr.first = first;
						pr.len   = cnt;
						if (live_runs.size() < 512)
							live_runs.push_back(pr);
					end else begin
						r.status = STS_NOMEM;
					end
				end else if (base_pg + cnt > NUM_PAGES) begin
					r.status = STS_RANGE;
				end else begin
					mark_run(base_pg, cnt, act == ACT_RESERVE);
				end
			end
			r.used_pages = COUNT_W'(used_total);
			r.free_pages = COUNT_W'(NUM_PAGES - used_total);
			expected_replies.push_back(r);
		endfunction

		function bit take_run(output int unsigned first, output int unsigned len);
			int idx;
			first = 0;
			len   = 0;
			if (live_runs.size() == 0)
				return 1'b0;
			idx   = $urandom_range(live_runs.size() - 1);
			first = live_runs[idx].first;
			len   = live_runs[idx].len;
			live_runs.delete(idx);
			return 1'b1;
		endfunction

		function int pending();
			return expected_replies.size();
		endfunction

		task report(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
			errors++;
			if (errors <= MAX_PRINTS)
				$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		endtask

		task check_response(logic [STATUS_W-1:0] status, logic [ADDR_W-1:0] run_address,
				logic [COUNT_W-1:0] used_pages, logic [COUNT_W-1:0] free_pages);
			alloc_reply_t want;
			if (expected_replies.size() == 0) begin
				report("response word with nothing pending", status, 0);
				return;
			end
			want = expected_replies.pop_front();
			if (status !== want.status)
				report("status", status, want.status);
			if (run_address !== want.run_address)
				report("run_address", run_address, want.run_address);
			if (used_pages !== want.used_pages)
				report("used_pages", used_pages, want.used_pages);
			if (free_pages !== want.free_pages)
				report("free_pages", free_pages, want.free_pages);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bpa_in_if  req();
	bpa_out_if rsp();

	bitmap_page_allocator_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	alloc_scoreboard sb = new();

	int          send_idle_pct = 0;
	int          rcv_stall_pct = 0;
	int          hold_ticket   = 0;
	longint      cycles        = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// response side: checks, random stalls and the long hold-off
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (rsp.valid && rsp.ready)
					sb.check_response(rsp.status, rsp.run_address, rsp.used_pages,
						rsp.free_pages);
				if (hold_left > 0) begin
					hold_left--;
					rsp.ready <= 1'b0;
				end else if (hold_ticket != hold_seen) begin
					hold_seen = hold_ticket;
					hold_left = HOLD_CYCLES;
					rsp.ready <= 1'b0;
				end else begin
					rsp.ready <= ($urandom_range(99) >= rcv_stall_pct);
				end
			end
		end
	end

	function automatic logic [ADDR_W-1:0] page_addr(int unsigned pg);
		return ADDR_W'(pg << PAGE_SHIFT) | ADDR_W'($urandom_range((1 << PAGE_SHIFT) - 1));
	endfunction

	function automatic int unsigned run_length();
		int unsigned k;
		k = $urandom_range(99);
		if (k < 55)
			return $urandom_range(1, 8);
		else if (k < 85)
			return $urandom_range(9, 64);
		else if (k < 97)
			return $urandom_range(65, 512);
		return $urandom_range(513, 2048);
	endfunction

	task automatic send_word(logic [ACTION_W-1:0] act, logic [ADDR_W-1:0] addr,
			logic [COUNT_W-1:0] cnt);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		req.valid        <= 1'b1;
		req.action       <= act;
		req.base_address <= addr;
		req.page_count   <= cnt;
		do
			@(posedge clk);
		while (!req.ready);
		sb.apply_request(act, addr, cnt);
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	// mostly well-formed alloc/free traffic, some noise and out-of-range runs
	task automatic pick_random_word(output logic [ACTION_W-1:0] act,
			output logic [ADDR_W-1:0] addr, output logic [COUNT_W-1:0] cnt);
		int unsigned roll;
		int unsigned pg;
		int unsigned first;
		int unsigned len;
		int unsigned alloc_bias;
		roll = $urandom_range(99);
		act  = ACT_ALLOC;
		addr = ADDR_W'($urandom);
		cnt  = COUNT_W'(run_length());
		if (roll < 8) begin
			act = ACTION_W'($urandom_range(3));
			cnt = $urandom_range(1) ? '0 : COUNT_W'($urandom);
		end else if (roll < 13) begin
			act  = $urandom_range(1) ? ACT_FREE : ACT_RESERVE;
			pg   = NUM_PAGES - $urandom_range(1, 64);
			cnt  = COUNT_W'(NUM_PAGES - pg + $urandom_range(1, 200));
			addr = page_addr(pg);
		end else begin
			if (sb.used_total < 1500)
				alloc_bias = 70;
			else if (sb.used_total > 3200)
				alloc_bias = 25;
			else
				alloc_bias = 50;
			roll = $urandom_range(99);
			if (roll >= alloc_bias) begin
				if (roll < 90 && sb.take_run(first, len)) begin
					act  = ACT_FREE;
					addr = page_addr(first);
					cnt  = COUNT_W'(len);
				end else begin
					act  = (roll < 95) ? ACT_FREE : ACT_RESERVE;
					pg   = $urandom_range(NUM_PAGES - 1);
					len  = run_length();
					if (pg + len > NUM_PAGES)
						len = NUM_PAGES - pg;
					addr = page_addr(pg);
					cnt  = COUNT_W'(len);
				end
			end
		end
	endtask

	initial begin
		logic [ACTION_W-1:0] act;
		logic [ADDR_W-1:0]   addr;
		logic [COUNT_W-1:0]  cnt;
		req.valid        <= 1'b0;
		req.action       <= ACT_ALLOC;
		req.base_address <= '0;
		req.page_count   <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty pool, zero counts, ignored action, range edges, first fit
		send_word(ACT_ALLOC, 24'h000000, 13'd1);
		send_word(ACT_ALLOC, 24'h000000, 13'd0);
		send_word(ACT_FREE, 24'h000000, 13'd0);
		send_word(ACT_RESERVE, 24'hFFFFFF, 13'd0);
		send_word(ACT_UNUSED, 24'h000000, 13'd5);
		send_word(ACT_UNUSED, 24'hABCDEF, 13'd0);
		send_word(ACT_FREE, 24'hFFFFFF, 13'd1);
		send_word(ACT_FREE, 24'hFFF000, 13'd2);
		send_word(ACT_RESERVE, 24'h000000, 13'h1FFF);
		send_word(ACT_ALLOC, 24'h000000, 13'd2);
		send_word(ACT_ALLOC, 24'h000000, 13'd1);
		send_word(ACT_FREE, 24'h000000, 13'd4096);
		send_word(ACT_ALLOC, 24'h000000, 13'd4097);
		send_word(ACT_ALLOC, 24'hFFFFFF, 13'h1FFF);
		send_word(ACT_ALLOC, 24'h000000, 13'd4096);
		send_word(ACT_FREE, 24'h800ABC, 13'd16);
		send_word(ACT_FREE, 24'h800000, 13'd8);
		send_word(ACT_RESERVE, 24'h804000, 13'd4);
		send_word(ACT_ALLOC, 24'h000000, 13'd5);
		send_word(ACT_ALLOC, 24'h000000, 13'd4);
		send_word(ACT_FREE, 24'h000FFF, 13'd4096);
		send_word(ACT_ALLOC, 24'h000000, 13'd1);
		send_word(ACT_RESERVE, 24'h7FF000, 13'd1);
		send_word(ACT_FREE, 24'h000000, 13'd4096);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					rcv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 63;
					rcv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					rcv_stall_pct = 63;
				end
				default: begin
					send_idle_pct = 27;
					rcv_stall_pct = 27;
				end
			endcase
			for (int i = 0; i < RAND_PER_PHASE; i++) begin
				if (ph == 0 && i == 120)
					hold_ticket <= hold_ticket + 1;
				if (ph == 1 && i == 150)
					wait_drained();
				pick_random_word(act, addr, cnt);
				send_word(act, addr, cnt);
			end
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
